### rtl/sorted_key_value_lookup_unit_defines.svh
// Assertion macros shared by the sorted key-value lookup RTL.
// No dependencies; expects a clock named clk and a reset named rst in scope.
`ifndef SORTED_KEY_VALUE_LOOKUP_UNIT_DEFINES_SVH
`define SORTED_KEY_VALUE_LOOKUP_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SKV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("skv assertion failed");

// Next-cycle implication, checked outside reset.
`define SKV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skv assertion failed");

`endif

### rtl/skv_pkg.sv
// Shared constants, codes and microcode table of the sorted key-value lookup.
// No dependencies.
`default_nettype none

package skv_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int ENTRY_W     = KEY_W + VAL_W;

  // request kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // microcode step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_FETCH   = 3'd0;
  localparam step_t STEP_CLEAR   = 3'd1;
  localparam step_t STEP_APPEND  = 3'd2;
  localparam step_t STEP_PROBE   = 3'd3;
  localparam step_t STEP_COMPARE = 3'd4;
  localparam step_t STEP_OTHER   = 3'd5;

  typedef enum logic [2:0] {
    OP_FETCH   = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_APPEND  = 3'd2,
    OP_PROBE   = 3'd3,
    OP_COMPARE = 3'd4,
    OP_IDLE_OK = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS   = 2'd0,
    COND_DISPATCH = 2'd1,
    COND_EMPTY    = 2'd2,
    COND_HIT      = 2'd3
  } cond_t;

  // one control word: datapath op, jump condition, taken target, fall-through
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t alt;
    step_t next;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    unique case (step)
      STEP_FETCH:   w = '{OP_FETCH,   COND_DISPATCH, STEP_FETCH, STEP_FETCH};
      STEP_CLEAR:   w = '{OP_CLEAR,   COND_ALWAYS,   STEP_FETCH, STEP_FETCH};
      STEP_APPEND:  w = '{OP_APPEND,  COND_ALWAYS,   STEP_FETCH, STEP_FETCH};
      STEP_PROBE:   w = '{OP_PROBE,   COND_EMPTY,    STEP_FETCH, STEP_COMPARE};
      STEP_COMPARE: w = '{OP_COMPARE, COND_HIT,      STEP_FETCH, STEP_PROBE};
      STEP_OTHER:   w = '{OP_IDLE_OK, COND_ALWAYS,   STEP_FETCH, STEP_FETCH};
      default:      w = '{OP_FETCH,   COND_ALWAYS,   STEP_FETCH, STEP_FETCH};
    endcase
    return w;
  endfunction

  // entry point of each request kind
  function automatic step_t dispatch(input logic [1:0] kind);
    step_t s;
    unique case (kind)
      KIND_CLEAR:  s = STEP_CLEAR;
      KIND_APPEND: s = STEP_APPEND;
      KIND_LOOKUP: s = STEP_PROBE;
      default:     s = STEP_OTHER;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/skv_req_if.sv
// Request channel of the sorted key-value lookup: valid/ready plus payload.
// Depends on skv_pkg for field widths.
`default_nettype none

interface skv_req_if
  import skv_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

`default_nettype wire

### rtl/skv_rsp_if.sv
// Result channel of the sorted key-value lookup: valid/ready plus payload.
// Depends on skv_pkg for field widths.
`default_nettype none

interface skv_rsp_if
  import skv_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] found_value;

  modport source (output valid, status, found_value, input ready);
  modport sink   (input valid, status, found_value, output ready);
endinterface

`default_nettype wire

### rtl/skv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module skv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/sorted_key_value_lookup_unit.sv
// Sorted key-value lookup: table loaded in ascending key order, binary-search lookups.
// Depends on skv_pkg, skv_req_if, skv_rsp_if, skv_ram and the defines header.
//
//   channel | dir | payload                 | handshake
//   --------+-----+-------------------------+-------------------
//   req     | in  | kind, key, value        | valid & ready
//   rsp     | out | status, found_value     | valid & ready
//
// Clear, append and unused kinds pass through fetch and one further step.
// A lookup alternates probe and compare steps after fetch and ends at a compare
// that hits or at a probe that finds the window empty, after at most
// log2(MAX_ENTRIES)+1 probes; each probe is a RAM read then a compare, set by
// the registered read port of the entry RAM.
// Reset clears the entry count, the step register and the result valid flag;
// the RAM keeps its contents and needs no clearing pass.
// A held result (rsp.valid & !rsp.ready) stalls every step but fetch.
`default_nettype none

`include "sorted_key_value_lookup_unit_defines.svh"

module sorted_key_value_lookup_unit
  import skv_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  skv_req_if.sink   req,
  skv_rsp_if.source rsp
);

  // sequencer
  step_t step;
  step_t step_next;
  ctrl_t ctrl;

  // latched request
  logic [1:0]              kind_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [VAL_W-1:0] value_r;

  // table bookkeeping
  logic [CNT_W-1:0]        entry_count;
  logic signed [KEY_W-1:0] last_key;

  // search window [lo, hi_ex)
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi_ex;
  logic [ADDR_W-1:0] mid;
  logic [CNT_W:0]    mid_sum;

  // RAM ports
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic signed [KEY_W-1:0] probe_key;
  logic signed [VAL_W-1:0] probe_value;

  // control terms
  logic hold;
  logic req_fire;
  logic range_empty;
  logic hit;
  logic table_full;
  logic append_bad;
  logic cond_true;
  logic emit;
  logic [1:0]              emit_status;
  logic signed [VAL_W-1:0] emit_value;

  assign ctrl = ucode(step);

  // result register occupied and not drained this cycle
  assign hold     = rsp.valid && !rsp.ready;
  assign req.ready = (ctrl.op == OP_FETCH);
  assign req_fire  = req.valid && req.ready;

  assign mid_sum     = {1'b0, lo} + {1'b0, hi_ex} - (CNT_W+1)'(1);
  assign mid         = mid_sum[ADDR_W:1];
  assign range_empty = (lo >= hi_ex);

  assign probe_key   = ram_rdata[ENTRY_W-1:VAL_W];
  assign probe_value = ram_rdata[VAL_W-1:0];
  assign hit         = (probe_key == key_r);

  // duplicate / out-of-order / overflow append gets dropped
  assign table_full = (entry_count == CNT_W'(MAX_ENTRIES));
  assign append_bad = table_full || ((entry_count != '0) && (key_r <= last_key));

  assign ram_we = (ctrl.op == OP_APPEND) && !hold && !append_bad;

  skv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[ADDR_W-1:0]),
    .wdata ({key_r, value_r}),
    .raddr (mid),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (ctrl.cond)
      COND_EMPTY: cond_true = range_empty;
      COND_HIT:   cond_true = hit;
      default:    cond_true = 1'b1;
    endcase
  end

  always_comb begin
    step_next = step;
    if (ctrl.op == OP_FETCH) begin
      if (req_fire) begin
        step_next = dispatch(req.kind);
      end
    end else if (!hold) begin
      step_next = cond_true ? ctrl.alt : ctrl.next;
    end
  end

  // which steps produce a result, and what it says
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_value  = '0;
    unique case (ctrl.op)
      OP_CLEAR, OP_IDLE_OK: begin
        emit = 1'b1;
      end
      OP_APPEND: begin
        emit        = 1'b1;
        emit_status = append_bad ? ST_REJECT : ST_OK;
      end
      OP_PROBE: begin
        emit        = range_empty;
        emit_status = ST_MISS;
      end
      OP_COMPARE: begin
        emit       = hit;
        emit_value = probe_value;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    emit = emit && !hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= STEP_FETCH;
      entry_count <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      step <= step_next;
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (!hold && ctrl.op == OP_CLEAR) begin
        entry_count <= '0;
      end else if (ram_we) begin
        entry_count <= entry_count + CNT_W'(1);
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      kind_r  <= req.kind;
      key_r   <= req.key;
      value_r <= req.value;
      lo      <= '0;
      hi_ex   <= entry_count;
    end
    if (ram_we) begin
      last_key <= key_r;
    end
    if (!hold && ctrl.op == OP_COMPARE && !hit) begin
      if (key_r < probe_key) begin
        hi_ex <= {1'b0, mid};
      end else begin
        lo <= {1'b0, mid} + CNT_W'(1);
      end
    end
    if (emit) begin
      rsp.status      <= emit_status;
      rsp.found_value <= emit_value;
    end
  end

  // kind_r is kept for debug visibility of the request in flight
  logic kind_lookup_inflight;
  assign kind_lookup_inflight = (kind_r == KIND_LOOKUP);

  `SKV_ASSERT_IMPL(a_count_bound, 1'b1, entry_count <= CNT_W'(MAX_ENTRIES))
  `SKV_ASSERT_NEXT(a_accept_leaves_fetch, req_fire, step != STEP_FETCH)
  `SKV_ASSERT_IMPL(a_compare_window, step == STEP_COMPARE, (lo < hi_ex) && kind_lookup_inflight)
  `SKV_ASSERT_IMPL(a_miss_zero_value, rsp.valid && rsp.status != ST_OK, rsp.found_value == '0)

endmodule

`default_nettype wire

### tb/sorted_key_value_lookup_checker.sv
// Checker for the sorted key-value lookup: mirrors the table, predicts each result.
// Depends on skv_pkg, skv_req_if and skv_rsp_if; reports a failure count to its parent.
module sorted_key_value_lookup_checker
  import skv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  skv_req_if   req,
  skv_rsp_if   rsp,
  output int   failures,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] found_value;
  } answer_t;

  logic signed [KEY_W-1:0] table_keys   [MAX_ENTRIES];
  logic signed [VAL_W-1:0] table_values [MAX_ENTRIES];
  int                      table_size;
  answer_t                 pending_answers [$];

  initial begin
    failures    = 0;
    outstanding = 0;
    table_size  = 0;
  end

  // Applies one request to the mirrored table and returns the answer it earns.
  function automatic answer_t answer_request(input logic [1:0] kind,
                                             input logic signed [KEY_W-1:0] key,
                                             input logic signed [VAL_W-1:0] value);
    answer_t a;
    int      lo;
    int      hi;
    int      mid;
    a.status      = ST_OK;
    a.found_value = '0;
    case (kind)
      KIND_CLEAR: begin
        table_size = 0;
      end
      KIND_APPEND: begin
        // full table, duplicate and descending keys are all dropped
        if (table_size == MAX_ENTRIES ||
            (table_size != 0 && key <= table_keys[table_size-1])) begin
          a.status = ST_REJECT;
        end else begin
          table_keys[table_size]   = key;
          table_values[table_size] = value;
          table_size++;
        end
      end
      KIND_LOOKUP: begin
        a.status = ST_MISS;
        lo       = 0;
        hi       = table_size - 1;
        while (lo <= hi && a.status == ST_MISS) begin
          mid = lo + (hi - lo) / 2;
          if (table_keys[mid] == key) begin
            a.status      = ST_OK;
            a.found_value = table_values[mid];
          end else if (key < table_keys[mid]) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      pending_answers.delete();
      table_size = 0;
    end else begin
      // result side first: a result never belongs to a request taken at this edge
      if (rsp.valid && rsp.ready) begin
        if (pending_answers.size() == 0) begin
          $error("unexpected result: status %0d found_value %0d",
                 rsp.status, rsp.found_value);
          failures++;
        end else begin
          want = pending_answers.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            failures++;
          end
          if (rsp.found_value !== want.found_value) begin
            $error("found_value: expected %0d, got %0d",
                   want.found_value, rsp.found_value);
            failures++;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_answers.push_back(answer_request(req.kind, req.key, req.value));
      end
    end
    outstanding = pending_answers.size();
  end

endmodule

### tb/tb.sv
// Top of the sorted key-value lookup testbench: clock, reset, request stimulus, result stalls.
// Depends on skv_pkg, both channel interfaces, the unit under test and the checker.
module tb;
  import skv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_REQUESTS   = 1500;
  // last stretch of the run goes without any idling on either side
  localparam int CALM_AFTER       = 1300;
  // long result-side hold-off, well past what the unit can buffer
  localparam int LONG_HOLD_CYCLES = 300;
  // slowest step between two handshakes: a full-table lookup, a request gap, the long hold
  localparam int WATCHDOG_LIMIT   = 2000;
  // drain time after the last result: one full 256-entry lookup and then some
  localparam int DRAIN_CYCLES     = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  skv_req_if req_ch ();
  skv_rsp_if rsp_ch ();

  int failure_count;
  int answers_pending;

  sorted_key_value_lookup_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sorted_key_value_lookup_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .failures    (failure_count),
    .outstanding (answers_pending)
  );

  // Stimulus knobs, changed per phase by the main sequence.
  int  requests_sent = 0;
  int  gap_pct       = 0;    // chance in percent of a gap before a request
  int  stall_pct     = 0;    // chance in percent of a result stall burst
  bit  hold_results  = 1'b0; // asks the result side for one long hold-off

  logic signed [KEY_W-1:0] loaded_keys [$];

  // ---------------------------------------------------------------------------
  // Result side: ready drops in random bursts, or once for a long
  // stretch while the request side keeps pushing, so the unit backs up.
  // ---------------------------------------------------------------------------
  initial begin
    int burst;
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
        hold_results = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        burst = $urandom_range(1, 14);
        rsp_ch.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a run with no handshake on either channel for too long is hung.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[sorted_key_value_lookup_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. A request is presented at a falling edge and held until a
  // rising edge sees ready; valid stays up back to back unless a gap is drawn.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] kind, input logic [31:0] key,
                              input logic [31:0] value);
    int gap;
    // the tail of the run goes without idling, whatever phase is running
    if (requests_sent >= CALM_AFTER) begin
      gap_pct   = 0;
      stall_pct = 0;
    end
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.key   <= key;
    req_ch.value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic stop_requests();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  // One phase of well-formed traffic: usually a clear, then load `entries` ascending
  // keys with random values, then look up stored keys and their neighbours. Broken appends,
  // unused kinds and stray lookups are sprinkled in as noise.
  task automatic load_and_query(input int entries, input bit dense);
    longint k;
    longint span;
    longint base;
    int     j;
    int     idx;
    int     pick;
    int     lookups;
    loaded_keys.delete();
    // now and then skip the clear, so appends run into an old table
    if ($urandom_range(0, 9) != 0) send_request(KIND_CLEAR, $urandom, $urandom);
    span = 0;
    base = 0;
    if (entries != 0) span = (64'sd1 << 32) / entries;
    // dense keys sit 1..3 apart, which makes near misses hit real neighbors
    if (dense) begin
      base = -(64'sd1 << 31) + (longint'($urandom) % ((64'sd1 << 32) - 3 * MAX_ENTRIES));
    end
    k = base;
    for (j = 0; j < entries; j++) begin
      if (dense) begin
        if (j != 0) k = k + $urandom_range(1, 3);
      end else begin
        // sparse keys: one per slice of the full signed range
        k = -(64'sd1 << 31) + j * span + (longint'($urandom) % span);
      end
      send_request(KIND_APPEND, k[31:0], $urandom);
      loaded_keys.push_back(k[31:0]);
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        send_request(KIND_APPEND, k[31:0], $urandom);        // duplicate key
      end else if (pick == 1) begin
        k = k - $urandom_range(1, 1000);
        send_request(KIND_APPEND, k[31:0], $urandom);        // descending key
        k = longint'(loaded_keys[$]);
      end else if (pick == 2) begin
        send_request(KIND_NONE, $urandom, $urandom);
      end else if (pick <= 4) begin
        idx = $urandom_range(0, loaded_keys.size() - 1);
        send_request(KIND_LOOKUP, loaded_keys[idx], $urandom);
      end
    end
    // appends past the last slot of a full table
    if (entries == MAX_ENTRIES) begin
      send_request(KIND_APPEND, 32'h7fff_ffff, $urandom);
      send_request(KIND_APPEND, $urandom, $urandom);
    end
    lookups = (entries == MAX_ENTRIES) ? 48 : entries + $urandom_range(1, entries + 4);
    for (j = 0; j < lookups; j++) begin
      pick = $urandom_range(0, 19);
      if (loaded_keys.size() == 0 || pick >= 17) begin
        send_request(KIND_LOOKUP, $urandom, $urandom);
      end else if (pick == 16) begin
        send_request(KIND_NONE, $urandom, $urandom);
      end else begin
        idx = $urandom_range(0, loaded_keys.size() - 1);
        k   = longint'(loaded_keys[idx]);
        // mostly hits; the rest probe one key either side of a stored one
        if (pick >= 12) k = $urandom_range(0, 1) ? k + 1 : k - 1;
        send_request(KIND_LOOKUP, k[31:0], $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    int entries;
    req_ch.valid = 1'b0;
    req_ch.kind  = KIND_NONE;
    req_ch.key   = '0;
    req_ch.value = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, unused kind, extreme keys and values, rejects.
    gap_pct   = 20;
    stall_pct = 20;
    send_request(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);   // empty table miss
    send_request(KIND_NONE,   32'hffff_ffff, 32'hffff_ffff);   // ignored kind
    send_request(KIND_CLEAR,  32'hffff_ffff, 32'hffff_ffff);
    send_request(KIND_APPEND, 32'h8000_0000, 32'h7fff_ffff);   // most negative key
    send_request(KIND_APPEND, 32'hffff_ffff, 32'hffff_ffff);
    send_request(KIND_APPEND, 32'h0000_0000, 32'h8000_0000);
    send_request(KIND_APPEND, 32'h0000_0001, 32'h5555_5555);
    send_request(KIND_APPEND, 32'h7fff_ffff, 32'haaaa_aaaa);   // most positive key
    send_request(KIND_APPEND, 32'h7fff_ffff, 32'h0000_0001);   // duplicate
    send_request(KIND_APPEND, 32'h0000_0005, 32'h0000_0002);   // out of order
    send_request(KIND_LOOKUP, 32'h8000_0000, 32'hffff_ffff);
    send_request(KIND_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
    send_request(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_request(KIND_LOOKUP, 32'h0000_0001, 32'h0000_0000);
    send_request(KIND_LOOKUP, 32'h7fff_ffff, 32'h0000_0000);
    send_request(KIND_LOOKUP, 32'h0000_0002, 32'h0000_0000);   // miss between keys
    send_request(KIND_LOOKUP, 32'h8000_0001, 32'h0000_0000);
    send_request(KIND_LOOKUP, 32'hffff_fffe, 32'h0000_0000);
    send_request(KIND_CLEAR,  32'h0000_0000, 32'h0000_0000);
    send_request(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);   // gone after clear
    send_request(KIND_APPEND, 32'h7fff_ffff, 32'h1234_5678);
    send_request(KIND_APPEND, 32'h8000_0000, 32'h1234_5678);   // lower than last
    send_request(KIND_LOOKUP, 32'h7fff_ffff, 32'h0000_0000);

    // Random phases of load-then-query traffic.
    phase = 0;
    while (requests_sent < TOTAL_REQUESTS) begin
      if (requests_sent >= CALM_AFTER) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          2:       gap_pct = 30;
          default: gap_pct = 60;
        endcase
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          2:       stall_pct = 30;
          default: stall_pct = 60;
        endcase
      end
      // mostly small tables; a full one early on and now and then after, but
      // none near the end so the request total stays close to the target
      if (phase == 1 || (requests_sent < CALM_AFTER && $urandom_range(0, 11) == 0)) begin
        entries = MAX_ENTRIES;
      end else begin
        entries = $urandom_range(0, 24);
      end
      // long hold-off while requests keep coming, forced once
      if (phase == 2) hold_results = 1'b1;
      load_and_query(entries, $urandom_range(0, 2) == 0);
      // let everything drain before the next phase, forced once
      if (phase == 3 || $urandom_range(0, 3) == 0) begin
        stop_requests();
        wait (answers_pending == 0);
      end
      phase++;
    end

    stop_requests();
    wait (answers_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failure_count == 0) begin
      $display("[sorted_key_value_lookup_unit] OK");
    end else begin
      $display("[sorted_key_value_lookup_unit] ERROR");
    end
    $finish;
  end

endmodule
